// File: rtl/utf8_unique_codepoint_collector_defines.svh
// assertion macros for the utf8 unique code point collector
`ifndef UTF8_UNIQUE_CODEPOINT_COLLECTOR_DEFINES_SVH
`define UTF8_UNIQUE_CODEPOINT_COLLECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked property, quiet while reset is high
`define UCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked during reset
`define UCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UCC_ASSERT(lbl, clk, rst, prop, msg)
`define UCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/utf8ucc_pkg.sv
// shared types and constants of the utf8 unique code point collector
package utf8ucc_pkg;

   localparam int MAX_UNIQUE   = 65536;
   localparam int COUNT_W      = $clog2(MAX_UNIQUE + 1);
   localparam int CP_W         = 21;
   localparam int BITMAP_WORDS = 34816;
   localparam int WORD_W       = 32;
   localparam int BIT_SEL_W    = $clog2(WORD_W);
   localparam int ADDR_W       = $clog2(BITMAP_WORDS);
   localparam int QUEUE_DEPTH  = 3;
   localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CP_LIMIT = 32'h0010_FFFF;
   localparam logic [31:0] SURR_LO  = 32'h0000_D800;
   localparam logic [31:0] SURR_HI  = 32'h0000_DFFF;
   localparam logic [CP_W-1:0] MIN_2BYTE = 21'h00080;
   localparam logic [CP_W-1:0] MIN_3BYTE = 21'h00800;
   localparam logic [CP_W-1:0] MIN_4BYTE = 21'h10000;
   localparam logic [7:0] ASCII_FIRST = 8'h20;

   typedef enum logic [0:0] {
      OP_BYTE   = 1'b0,
      OP_DIRECT = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      STATUS_ADDED = 1'b0,
      STATUS_LIMIT = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      LEN_NONE  = 2'd0,
      LEN_2BYTE = 2'd1,
      LEN_3BYTE = 2'd2,
      LEN_4BYTE = 2'd3
   } len_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      status_type      status;
   } result_type;

endpackage

// File: rtl/utf8ucc_if.sv
// valid/ready channel interfaces for request and response transactions
interface utf8ucc_req_if import utf8ucc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  data_byte;
   logic [31:0] direct_point;
   logic        new_stream;

   modport source (output valid, op, data_byte, direct_point, new_stream, input ready);
   modport sink (input valid, op, data_byte, direct_point, new_stream, output ready);
endinterface

interface utf8ucc_rsp_if import utf8ucc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            status;

   modport source (output valid, code_point, status, input ready);
   modport sink (input valid, code_point, status, output ready);
endinterface

// File: rtl/utf8ucc_ram.sv
// generic single write port, single read port ram with registered read
module utf8ucc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/utf8_unique_codepoint_collector.sv
// top level: utf8 decoder with seen-bitmap duplicate filter
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   op, data_byte, direct_point, new_stream
//   rsp_chan  out  valid/ready   code_point, status
//
// one request transaction per cycle while ready is high; each result passes through
// decode and bitmap read, then bitmap check and write back into a 3-entry queue
// after reset a clearing pass writes all 34816 bitmap words, with ready low
// back-to-back hits on one bitmap word are served from a forwarding register
// ready drops during the clearing pass and while the response queue plus the item in flight would fill it
module utf8_unique_codepoint_collector import utf8ucc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   utf8ucc_req_if.sink  req_chan,
   utf8ucc_rsp_if.source rsp_chan
);

`include "utf8_unique_codepoint_collector_defines.svh"

   // decoder state
   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      remain_ff, remain_in;
   len_type         len_ff, len_in;

   // clearing pass
   logic              clear_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // bitmap stage
   logic              s1_valid_ff;
   logic [CP_W-1:0]   s1_point_ff;
   logic              fwd_ff, fwd_in;
   logic [WORD_W-1:0] fwd_word_ff;
   logic [COUNT_W-1:0] count_ff;
   logic              halted_ff;

   // response queue
   result_type        q_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] head_ff, tail_ff;
   logic [QCNT_W-1:0] q_count_ff;

   logic        accept;
   logic        cand_raw, cand;
   logic [31:0] cand_point;
   logic [CP_W-1:0] pv, acc, minimum;
   logic [1:0]  br;
   len_type     cls;
   logic [7:0]  b;

   logic [WORD_W-1:0] word, mask, word_upd;
   logic              seen, live, add, limit, push, pop;
   logic              ram_we, rd_en;
   logic [ADDR_W-1:0] ram_wa, rd_addr;
   logic [WORD_W-1:0] ram_wd, rd_data;
   result_type        push_data;
   logic [QCNT_W:0]   occupancy;

   assign occupancy = {1'b0, q_count_ff} + {{QCNT_W{1'b0}}, s1_valid_ff};
   assign req_chan.ready = !clear_busy_ff && (occupancy <= (QCNT_W+1)'(QUEUE_DEPTH - 1));
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.data_byte;

   // byte decoder
   always_comb begin
      pv  = req_chan.new_stream ? '0 : partial_ff;
      br  = req_chan.new_stream ? 2'd0 : remain_ff;
      cls = req_chan.new_stream ? LEN_NONE : len_ff;
      partial_in = pv;
      remain_in  = br;
      len_in     = cls;
      cand_raw   = 1'b0;
      cand_point = '0;
      acc        = {pv[CP_W-7:0], b[5:0]};
      case (cls)
         LEN_2BYTE: minimum = MIN_2BYTE;
         LEN_3BYTE: minimum = MIN_3BYTE;
         default:   minimum = MIN_4BYTE;
      endcase
      if (op_type'(req_chan.op) == OP_DIRECT) begin
         cand_raw   = 1'b1;
         cand_point = req_chan.direct_point;
      end else if (br == 2'd0) begin
         if (!b[7]) begin
            if (b >= ASCII_FIRST) begin
               cand_raw   = 1'b1;
               cand_point = {24'b0, b};
            end
         end else if ((b & 8'hE0) == 8'hC0) begin
            partial_in = {16'b0, b[4:0]};
            len_in     = LEN_2BYTE;
            remain_in  = 2'd1;
         end else if ((b & 8'hF0) == 8'hE0) begin
            partial_in = {17'b0, b[3:0]};
            len_in     = LEN_3BYTE;
            remain_in  = 2'd2;
         end else if ((b & 8'hF8) == 8'hF0) begin
            partial_in = {18'b0, b[2:0]};
            len_in     = LEN_4BYTE;
            remain_in  = 2'd3;
         end
      end else if ((b & 8'hC0) != 8'h80) begin
         // broken sequence
         partial_in = '0;
         remain_in  = 2'd0;
         len_in     = LEN_NONE;
      end else if (br == 2'd1) begin
         partial_in = '0;
         remain_in  = 2'd0;
         len_in     = LEN_NONE;
         if (acc >= minimum) begin
            cand_raw   = 1'b1;
            cand_point = {{(32-CP_W){1'b0}}, acc};
         end
      end else begin
         partial_in = acc;
         remain_in  = br - 2'd1;
      end
      cand = cand_raw && !halted_ff && (cand_point <= CP_LIMIT) &&
             !((cand_point >= SURR_LO) && (cand_point <= SURR_HI));
   end

   assign rd_en   = accept && cand;
   assign rd_addr = cand_point[CP_W-1:BIT_SEL_W];

   // bitmap check and update
   always_comb begin
      word     = fwd_ff ? fwd_word_ff : rd_data;
      mask     = WORD_W'(1) << s1_point_ff[BIT_SEL_W-1:0];
      word_upd = word | mask;
      seen     = |(word & mask);
      live     = s1_valid_ff && !halted_ff && !seen;
      add      = live && (count_ff < COUNT_W'(MAX_UNIQUE));
      limit    = live && (count_ff >= COUNT_W'(MAX_UNIQUE));
      push     = add || limit;
      push_data.code_point = add ? s1_point_ff : '0;
      push_data.status     = add ? STATUS_ADDED : STATUS_LIMIT;
      ram_we = clear_busy_ff || add;
      ram_wa = clear_busy_ff ? clr_addr_ff : s1_point_ff[CP_W-1:BIT_SEL_W];
      ram_wd = clear_busy_ff ? '0 : word_upd;
      fwd_in = add && rd_en && (rd_addr == s1_point_ff[CP_W-1:BIT_SEL_W]);
   end

   utf8ucc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BITMAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         remain_ff     <= 2'd0;
         len_ff        <= LEN_NONE;
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         q_count_ff    <= '0;
      end else begin
         if (accept) begin
            partial_ff <= partial_in;
            remain_ff  <= remain_in;
            len_ff     <= len_in;
         end
         if (clear_busy_ff) begin
            if (clr_addr_ff == ADDR_W'(BITMAP_WORDS - 1)) begin
               clear_busy_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         s1_valid_ff <= rd_en;
         fwd_ff      <= fwd_in;
         if (add) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (limit) begin
            halted_ff <= 1'b1;
         end
         if (push) begin
            tail_ff <= (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QIDX_W'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QIDX_W'(1);
         end
         if (push && !pop) begin
            q_count_ff <= q_count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            q_count_ff <= q_count_ff - QCNT_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_point_ff <= cand_point[CP_W-1:0];
      end
      if (fwd_in) begin
         fwd_word_ff <= word_upd;
      end
      if (push) begin
         q_ff[tail_ff] <= push_data;
      end
   end

   assign rsp_chan.valid      = (q_count_ff != '0);
   assign rsp_chan.code_point = q_ff[head_ff].code_point;
   assign rsp_chan.status     = q_ff[head_ff].status;

   `UCC_ASSERT(a_queue_no_overflow, clock, reset, push |-> (q_count_ff != QCNT_W'(QUEUE_DEPTH)) || pop, "response queue overflow")
   `UCC_ASSERT(a_no_accept_clearing, clock, reset, clear_busy_ff |-> !s1_valid_ff && !fwd_ff, "bitmap stage active during clearing pass")
   `UCC_ASSERT(a_halt_no_update, clock, reset, (halted_ff && !clear_busy_ff) |-> !ram_we && !push, "bitmap written or result pushed after halt")
   `UCC_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_W'(MAX_UNIQUE), "unique count beyond limit")
   `UCC_ASSERT(a_fwd_has_item, clock, reset, fwd_ff |-> s1_valid_ff, "forwarded word without an item in the bitmap stage")

endmodule

// File: test/tb_top.sv
// testbench for the utf8 unique code point collector: decoder, duplicate filter, limit
`timescale 1ns / 100ps

module tb_top;
   import utf8ucc_pkg::*;

   // the clearing pass after reset holds ready low
   localparam int unsigned WATCHDOG_CYCLES = 200000;
   localparam int unsigned TAIL_CYCLES     = 8;

   logic clock;
   logic reset;

   utf8ucc_req_if req_chan();
   utf8ucc_rsp_if rsp_chan();

   utf8_unique_codepoint_collector i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted collector state
   logic [CP_W-1:0] dec_value     = '0;
   logic [1:0]      dec_remaining = '0;
   len_type         dec_len       = LEN_NONE;
   bit              seen_map [0:(1 << CP_W) - 1];
   int unsigned     added_count   = 0;
   bit              halted        = 1'b0;

   result_type  pending_points[$];
   int unsigned error_count    = 0;
   int unsigned accepted_items = 0;
   int unsigned issued_items   = 0;
   int unsigned checked_points = 0;
   int unsigned idle_cycles    = 0;
   bit          no_idle        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_decoder();
      dec_value     = '0;
      dec_remaining = '0;
      dec_len       = LEN_NONE;
   endfunction

   function automatic void note_point(logic [31:0] cp);
      result_type r;
      if (cp > CP_LIMIT || (cp >= SURR_LO && cp <= SURR_HI)) return;
      if (seen_map[cp[CP_W-1:0]]) return;
      if (added_count >= MAX_UNIQUE) begin
         halted = 1'b1;
         r.code_point = '0;
         r.status     = STATUS_LIMIT;
         pending_points.push_back(r);
         return;
      end
      seen_map[cp[CP_W-1:0]] = 1'b1;
      added_count++;
      r.code_point = cp[CP_W-1:0];
      r.status     = STATUS_ADDED;
      pending_points.push_back(r);
   endfunction

   function automatic void decode_and_filter(op_type op, logic [7:0] b, logic [31:0] dp,
                                             logic fresh);
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] minimum;
      if (halted) return;
      if (fresh) clear_decoder();
      if (op == OP_DIRECT) begin
         note_point(dp);
         return;
      end
      if (dec_remaining == 2'd0) begin
         if (b < 8'h80) begin
            if (b >= ASCII_FIRST) note_point({24'd0, b});
         end else if (b[7:5] == 3'b110) begin
            dec_value     = {16'd0, b[4:0]};
            dec_len       = LEN_2BYTE;
            dec_remaining = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            dec_value     = {17'd0, b[3:0]};
            dec_len       = LEN_3BYTE;
            dec_remaining = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            dec_value     = {18'd0, b[2:0]};
            dec_len       = LEN_4BYTE;
            dec_remaining = 2'd3;
         end
         return;
      end
      // anything but a continuation byte aborts the open sequence
      if (b[7:6] != 2'b10) begin
         clear_decoder();
         return;
      end
      dec_value = {dec_value[CP_W-7:0], b[5:0]};
      dec_remaining--;
      if (dec_remaining != 2'd0) return;
      minimum = (dec_len == LEN_2BYTE) ? MIN_2BYTE :
                (dec_len == LEN_3BYTE) ? MIN_3BYTE : MIN_4BYTE;
      cp = dec_value;
      clear_decoder();
      if (cp >= minimum) note_point({11'd0, cp});
   endfunction

   // monitor: predicts on each request transaction, checks each response transaction
   always @(posedge clock) begin
      rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 8);
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            decode_and_filter(op_type'(req_chan.op), req_chan.data_byte,
                              req_chan.direct_point, req_chan.new_stream);
            accepted_items++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected result code_point %h status %h", $time,
                        rsp_chan.code_point, rsp_chan.status);
               error_count++;
            end else begin
               if (rsp_chan.code_point !== pending_points[0].code_point) begin
                  $display("%0t: code_point expected %h actual %h", $time,
                           pending_points[0].code_point, rsp_chan.code_point);
                  error_count++;
               end
               if (rsp_chan.status !== pending_points[0].status) begin
                  $display("%0t: status expected %h actual %h", $time,
                           pending_points[0].status, rsp_chan.status);
                  error_count++;
               end
               void'(pending_points.pop_front());
               checked_points++;
            end
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_CYCLES) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("simulation failed");
      $finish;
   end

   task automatic send_item(op_type op, logic [7:0] b, logic [31:0] dp, logic fresh);
      if (!no_idle && $urandom_range(0, 99) < 8) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.data_byte    <= b;
      req_chan.direct_point <= dp;
      req_chan.new_stream   <= fresh;
      do @(posedge clock); while (!req_chan.ready);
      issued_items++;
   endtask

   task automatic send_byte(logic [7:0] b, logic fresh);
      send_item(OP_BYTE, b, $urandom, fresh);
   endtask

   task automatic send_direct(logic [31:0] dp, logic fresh);
      send_item(OP_DIRECT, 8'($urandom_range(0, 255)), dp, fresh);
   endtask

   // encodes the low payload bits of v in an n-byte form, overlong values included
   task automatic send_utf8(logic [CP_W-1:0] v, int unsigned n, logic fresh);
      case (n)
         2: begin
            send_byte({3'b110, v[10:6]}, fresh);
            send_byte({2'b10, v[5:0]}, 1'b0);
         end
         3: begin
            send_byte({4'b1110, v[15:12]}, fresh);
            send_byte({2'b10, v[11:6]}, 1'b0);
            send_byte({2'b10, v[5:0]}, 1'b0);
         end
         default: begin
            send_byte({5'b11110, v[20:18]}, fresh);
            send_byte({2'b10, v[17:12]}, 1'b0);
            send_byte({2'b10, v[11:6]}, 1'b0);
            send_byte({2'b10, v[5:0]}, 1'b0);
         end
      endcase
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic test_directed_cases();
      // control bytes, ascii extremes, duplicate
      send_byte(8'h00, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h20, 1'b0);
      // overlong two-byte form of 0x7f
      send_byte(8'hC1, 1'b0);
      send_byte(8'hBF, 1'b0);
      // surrogate U+D800
      send_utf8(21'h0D800, 3, 1'b0);
      // highest legal point
      send_utf8(21'h10FFFF, 4, 1'b0);
      // stray continuation and invalid lead
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      // broken sequence drops the interrupting byte
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_direct(32'h0000_0000, 1'b0);
      send_direct(32'hFFFF_FFFF, 1'b1);
      // direct insert inside an open sequence leaves it intact
      send_byte(8'hE2, 1'b0);
      send_direct(32'h0000_001F, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      // new stream abandons the half-done sequence
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h7E, 1'b1);
   endtask

   task automatic test_random_mix(int unsigned count);
      int unsigned     first;
      int unsigned     kind;
      int unsigned     n;
      int unsigned     k;
      logic [CP_W-1:0] v;
      logic [31:0]     dp;
      logic [7:0]      b;
      logic            fresh;
      first = issued_items;
      while (issued_items - first < count) begin
         kind  = $urandom_range(0, 99);
         fresh = ($urandom_range(0, 19) == 0);
         n     = $urandom_range(2, 4);
         if (kind < 30) begin
            send_byte(8'($urandom_range(0, 127)), fresh);
         end else if (kind < 65) begin
            // half from a small pool per length so duplicates show up
            if ($urandom_range(0, 1))
               v = (n == 2 ? 21'h00100 : n == 3 ? 21'h04E00 : 21'h1F600) +
                   21'($urandom_range(0, 63));
            else
               v = 21'($urandom);
            send_utf8(v, n, fresh);
         end else if (kind < 80) begin
            case ($urandom_range(0, 4))
               0: dp = $urandom;
               1: dp = $urandom_range(0, CP_LIMIT);
               2: dp = $urandom_range(SURR_LO - 2, SURR_HI + 2);
               3: dp = $urandom_range(0, 63);
               default: dp = CP_LIMIT - 1 + $urandom_range(0, 2);
            endcase
            send_direct(dp, fresh);
         end else if (kind < 90) begin
            send_byte(8'($urandom_range(0, 255)), fresh);
         end else begin
            // lead, too few continuations, then a non-continuation byte
            v = 21'($urandom);
            send_byte(n == 2 ? {3'b110, v[4:0]} : n == 3 ? {4'b1110, v[3:0]} :
                      {5'b11110, v[2:0]}, fresh);
            k = $urandom_range(0, n - 2);
            repeat (k) send_byte({2'b10, 6'($urandom)}, 1'b0);
            b = 8'($urandom_range(0, 191));
            if (b >= 8'h80) b = b + 8'h40;
            send_byte(b, 1'b0);
         end
      end
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      test_random_mix(300);
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_unique_limit();
      logic [31:0] cp;
      int unsigned needed;
      wait_drained();
      cp = 0;
      needed = MAX_UNIQUE - added_count;
      // one extra new point past the fill trips the limit
      repeat (needed + 1) begin
         while (seen_map[cp[CP_W-1:0]] || (cp >= SURR_LO && cp <= SURR_HI)) cp++;
         send_direct(cp, 1'($urandom));
         cp++;
      end
   endtask

   task automatic test_halted_input();
      test_random_mix(40);
      send_byte(8'hE4, 1'b1);
      send_byte(8'hB8, 1'b0);
      send_byte(8'h80, 1'b0);
      send_direct(32'h0010_FFF0, 1'b1);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.op           <= OP_BYTE;
      req_chan.data_byte    <= '0;
      req_chan.direct_point <= '0;
      req_chan.new_stream   <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_mix(900);
      test_back_to_back();
      test_unique_limit();
      test_halted_input();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d request transactions, %0d results checked", accepted_items,
               checked_points);
      $display("distinct points held %0d, unique limit reached: %0d", added_count, halted);
      if (error_count == 0 && pending_points.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: utf8_unique_codepoint_collector.f
+incdir+rtl
rtl/utf8ucc_pkg.sv
rtl/utf8ucc_if.sv
rtl/utf8ucc_ram.sv
rtl/utf8_unique_codepoint_collector.sv
test/tb_top.sv
